>>> rtl/fbh_pkg.sv
package fbh_pkg;

  localparam int unsigned CountW = 21;
  localparam int unsigned IndexW = 20;
  localparam int unsigned HashW  = 32;
  localparam int unsigned SumW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DvdW   = 31;
  localparam int unsigned StepW  = 5;

  localparam logic [HashW-1:0]  FnvBasis   = 32'h811C9DC5;
  localparam logic [HashW-1:0]  FnvPrime   = 32'h01000193;
  localparam logic [CountW-1:0] CountReset = 21'd1024;
  localparam logic [StepW-1:0]  LastStep   = 5'(DvdW - 1);

  typedef struct packed {
    logic [DvdW-1:0] hash;
    logic [SumW-1:0] sum;
  } fbh_key_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fbh_q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fbh_q_stat_t;

  typedef enum logic [2:0] {
    BackIdle = 3'b001,
    BackDiv  = 3'b010,
    BackDone = 3'b100
  } fbh_back_state_e;

endpackage

>>> rtl/fbh_in_if.sv
interface fbh_in_if import fbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] key_byte;
  logic             last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

>>> rtl/fbh_out_if.sv
interface fbh_out_if import fbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] bucket_index;
  logic [SumW-1:0]   byte_sum;

  modport source (output valid, output bucket_index, output byte_sum, input ready);
  modport sink (input valid, input bucket_index, input byte_sum, output ready);
endinterface

>>> rtl/fbh_front.sv
module fbh_front import fbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbh_in_if.sink      in_i,
  input  fbh_q_stat_t q_stat_i,
  output logic        push_o,
  output fbh_key_t    key_o
);

  logic [HashW-1:0] hash_q, hash_d, hash_next;
  logic [SumW-1:0]  sum_q, sum_d, sum_next;
  logic             accept;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign hash_next = HashW'((hash_q ^ {{(HashW-ByteW){1'b0}}, in_i.key_byte}) * FnvPrime);
  assign sum_next  = sum_q + {{(SumW-ByteW){1'b0}}, in_i.key_byte};

  assign push_o     = accept && in_i.last_byte;
  assign key_o.hash = hash_next[DvdW-1:0];
  assign key_o.sum  = sum_next;

  always_comb begin
    hash_d = hash_q;
    sum_d  = sum_q;
    if (accept) begin
      if (in_i.last_byte) begin
        hash_d = FnvBasis;
        sum_d  = '0;
      end else begin
        hash_d = hash_next;
        sum_d  = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
      sum_q  <= '0;
    end else begin
      hash_q <= hash_d;
      sum_q  <= sum_d;
    end
  end

endmodule

>>> rtl/fbh_fifo.sv
module fbh_fifo import fbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fbh_q_ctrl_t ctrl_i,
  input  fbh_key_t    key_i,
  output fbh_q_stat_t stat_o,
  output fbh_key_t    key_o
);

  fbh_key_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign key_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/fbh_back.sv
module fbh_back import fbh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] divisor_i,
  input  fbh_q_stat_t       q_stat_i,
  input  fbh_key_t          key_i,
  output logic              pop_o,
  fbh_out_if.source         out_o
);

  fbh_back_state_e   state_q, state_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW:0]   rem_shift, trial;

  assign rem_shift = {rem_q, dvd_q[DvdW-1]};
  assign trial     = rem_shift - {1'b0, divisor_i};

  assign out_o.valid        = (state_q == BackDone);
  assign out_o.bucket_index = rem_q[IndexW-1:0];
  assign out_o.byte_sum     = sum_q;

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          dvd_d   = key_i.hash;
          sum_d   = key_i.sum;
          rem_d   = '0;
          step_d  = '0;
          state_d = BackDiv;
        end
      end
      BackDiv: begin
        // restoring step, one dividend bit per cycle
        dvd_d  = {dvd_q[DvdW-2:0], 1'b0};
        rem_d  = trial[CountW] ? rem_shift[CountW-1:0] : trial[CountW-1:0];
        step_d = step_q + 5'd1;
        if (step_q == LastStep) begin
          state_d = BackDone;
        end
      end
      BackDone: begin
        if (out_o.ready) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> rtl/fnv1a_bucket_hash_top.sv
// Streaming FNV-1a bucket hash. The front end takes one key byte per cycle
// while the queue is not full and keeps the running 32-bit hash and byte sum;
// on the byte flagged last_byte it hands the top-bit-cleared hash and the sum
// to a two-key queue and restarts. The back end reduces each queued hash
// modulo the bucket count with a restoring remainder unit, one dividend bit
// per cycle: it loads a key while idle, shifts in every dividend bit, then
// holds the result until it is taken, and only after that loads another key.
// A bucket count of 0 acts as 1 and counts above MAX_BUCKETS saturate.
// Write cfg_we_i only while no key is in flight.
module fnv1a_bucket_hash_top import fbh_pkg::*; #(
  parameter longint unsigned MAX_BUCKETS = 1048576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  fbh_in_if.sink            in_i,
  fbh_out_if.source         out_o
);

  localparam logic [31:0] MaxCount = 32'(MAX_BUCKETS);

  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c == '0) begin
      r = CountW'(1);
    end else if ({{(32-CountW){1'b0}}, c} > MaxCount) begin
      r = MaxCount[CountW-1:0];
    end
    return r;
  endfunction

  logic [CountW-1:0] divisor_q;
  fbh_q_ctrl_t       q_ctrl;
  fbh_q_stat_t       q_stat;
  fbh_key_t          push_key, head_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= eff_count(CountReset);
    end else if (cfg_we_i) begin
      divisor_q <= eff_count(cfg_wdata_i);
    end
  end

  fbh_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (q_ctrl.push),
    .key_o    (push_key)
  );

  fbh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .key_i  (push_key),
    .stat_o (q_stat),
    .key_o  (head_key)
  );

  fbh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (divisor_q),
    .q_stat_i  (q_stat),
    .key_i     (head_key),
    .pop_o     (q_ctrl.pop),
    .out_o     (out_o)
  );

endmodule

>>> rtl/fbh_checker.sv
module fbh_checker import fbh_pkg::*; #(
  parameter longint unsigned MAX_BUCKETS = 1048576
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [CountW-1:0] cfg_wdata_i,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [IndexW-1:0] out_index_i,
  input logic [SumW-1:0]   out_sum_i
);

  localparam logic [31:0] MaxCount = 32'(MAX_BUCKETS);

  logic [CountW-1:0] count_q;
  logic [2:0]        pend_q;
  logic [31:0]       eff;
  logic              key_done, res_done;

  assign key_done = in_valid_i && in_ready_i && in_last_i;
  assign res_done = out_valid_i && out_ready_i;

  always_comb begin
    eff = {{(32-CountW){1'b0}}, count_q};
    if (count_q == '0) begin
      eff = 32'd1;
    end else if (eff > MaxCount) begin
      eff = MaxCount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      pend_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      pend_q <= pend_q + {2'b0, key_done} - {2'b0, res_done};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) && $stable(out_sum_i))
    else $error("result changed while stalled");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {12'b0, out_index_i} < eff)
    else $error("bucket index not below bucket count");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without a finished key");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd3 |-> !key_done)
    else $error("more keys in flight than storage allows");

endmodule

bind fnv1a_bucket_hash_top fbh_checker #(.MAX_BUCKETS(MAX_BUCKETS)) u_fbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.bucket_index),
  .out_sum_i   (out_o.byte_sum)
);

>>> bench/tb_fnv1a_bucket_hash_top.sv
module tb_fnv1a_bucket_hash_top;
  import fbh_pkg::*;

  localparam logic [HashW-1:0] MaxBuckets = 32'd1048576;
  localparam logic [HashW-1:0] HashKeep   = 32'h7FFFFFFF;
  localparam int unsigned SettleCycles    = 48;
  localparam int unsigned HoldCycles      = 400;
  localparam int unsigned CycleLimit      = 500000;

  typedef struct packed {
    logic [IndexW-1:0] bucket;
    logic [SumW-1:0]   total;
  } bucket_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  fbh_in_if  in_bus ();
  fbh_out_if out_bus ();

  fnv1a_bucket_hash_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  bucket_result_t    pending_buckets[$];
  logic [HashW-1:0]  key_hash = FnvBasis;
  logic [SumW-1:0]   key_sum = '0;
  logic [CountW-1:0] bucket_count_now = CountReset;
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;
  int unsigned       keys_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       cycle_count = 0;
  int unsigned       hold_left = 0;
  logic              hold_req = 1'b0;
  bit                src_steady = 1'b0;
  bit                sink_steady = 1'b0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side ready, with random stalls and a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HoldCycles;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= sink_steady || ($urandom_range(99) >= 12);
    end
  end

  // running fnv-1a hash and byte sum per accepted item
  always @(posedge clk_i) begin : key_tracker
    logic [HashW-1:0] h;
    logic [SumW-1:0]  s;
    logic [HashW-1:0] divisor;
    bucket_result_t   res;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      h = (key_hash ^ HashW'(in_bus.key_byte)) * FnvPrime;
      s = key_sum + SumW'(in_bus.key_byte);
      if (in_bus.last_byte) begin
        if (bucket_count_now == '0) begin
          divisor = 32'd1;
        end else if (HashW'(bucket_count_now) > MaxBuckets) begin
          divisor = MaxBuckets;
        end else begin
          divisor = HashW'(bucket_count_now);
        end
        res.bucket = IndexW'((h & HashKeep) % divisor);
        res.total = s;
        pending_buckets.push_back(res);
        key_hash = FnvBasis;
        key_sum = '0;
      end else begin
        key_hash = h;
        key_sum = s;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    bucket_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_buckets.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: bucket_index %0d byte_sum %0d", $time,
                 out_bus.bucket_index, out_bus.byte_sum);
      end else begin
        want = pending_buckets.pop_front();
        if (out_bus.bucket_index !== want.bucket) begin
          mismatches++;
          $display("%0t: bucket_index expected %0d actual %0d", $time, want.bucket,
                   out_bus.bucket_index);
        end
        if (out_bus.byte_sum !== want.total) begin
          mismatches++;
          $display("%0t: byte_sum expected %0d actual %0d", $time, want.total,
                   out_bus.byte_sum);
        end
      end
    end
  end

  task automatic send_item(input logic [ByteW-1:0] b, input logic last);
    if (!src_steady) begin
      while ($urandom_range(99) < 12) begin
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_bus.valid <= 1'b1;
    in_bus.key_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
    if (last) keys_sent++;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return ByteW'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 64);
  endfunction

  task automatic send_key(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pick_byte(), i == len - 1);
    end
  endtask

  task automatic wait_results();
    in_bus.valid <= 1'b0;
    while (results_seen < keys_sent) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CountW-1:0] value);
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bucket_count_now = value;
  endtask

  function automatic logic [CountW-1:0] phase_count(input int p);
    case (p)
      0: return 21'd1024;
      1: return 21'd1;
      2: return 21'd0;
      3: return 21'd2;
      4: return 21'd3;
      5: return 21'd1048576;
      6: return 21'h1FFFFF;
      7: return 21'd1048575;
      8: return 21'd1048577;
      9: return CountW'($urandom_range(1, 1048576));
      10: return CountW'($urandom);
      default: return CountW'($urandom_range(2, 4096));
    endcase
  endfunction

  task automatic test_default_count();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h61, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b1);
    repeat (3) send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_count_extremes();
    write_bucket_count(21'd1);
    send_item(8'h55, 1'b1);
    // zero acts as a single bucket
    write_bucket_count(21'd0);
    send_item(8'hAA, 1'b1);
    write_bucket_count(21'd1048576);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    // above the maximum saturates
    write_bucket_count(21'h1FFFFF);
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b1);
    write_bucket_count(21'd2);
    send_item(8'h01, 1'b1);
  endtask

  task automatic test_output_hold_off();
    write_bucket_count(21'd999983);
    src_steady = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (40) send_item(pick_byte(), 1'b1);
    src_steady = 1'b0;
    wait_results();
  endtask

  task automatic test_random_keys();
    int unsigned target;
    for (int p = 0; p < 12; p++) begin
      write_bucket_count(phase_count(p));
      src_steady = (p == 5);
      sink_steady = (p == 5);
      target = items_sent + 100;
      while (items_sent < target) begin
        send_key(pick_len());
        if ($urandom_range(19) == 0) wait_results();
      end
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.key_byte = '0;
    in_bus.last_byte = 1'b0;
    out_bus.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_count();
    test_count_extremes();
    test_output_hold_off();
    test_random_keys();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
